[hw/rtl/rgb_3x3_convolution_filter_assert.svh]
// assertion macros for the rgb 3x3 convolution filter
`ifndef RGB_3X3_CONVOLUTION_FILTER_ASSERT_SVH
`define RGB_3X3_CONVOLUTION_FILTER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define R3C_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// trigger in one cycle implies result in the next
`define R3C_ASSERT_NEXT(lbl, trig, res, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error(msg);

`endif

[hw/rtl/r3c_pkg.sv]
// shared types, register codes and arithmetic helpers of the convolution filter
package r3c_pkg;

    typedef logic [23:0] pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic valid;
        logic row_top;
        logic row_bot;
        logic col_left;
        logic col_right;
        logic frame_end;
    } ctrl_t;

    localparam logic [1:0] REG_KERNEL = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [2:0] KSEL_MEAN  = 3'd0;
    localparam logic [2:0] KSEL_GAUSS = 3'd1;
    localparam logic [2:0] KSEL_HIGH  = 3'd2;
    localparam logic [2:0] KSEL_SOBX  = 3'd3;
    localparam logic [2:0] KSEL_SOBY  = 3'd4;

    localparam int SUM_W = 14;

    // reciprocal of 9 in q16, exact for the sum range
    localparam logic [12:0] RECIP9 = 13'd7282;

    function automatic logic signed [4:0] tap(input logic [2:0] sel,
                                               input int i, input int j);
        logic signed [4:0] t;
        t = 5'sd0;
        case (sel)
            KSEL_MEAN:  t = 5'sd1;
            KSEL_GAUSS: t = (i == 1 && j == 1) ? 5'sd4 :
                            ((i == 1 || j == 1) ? 5'sd2 : 5'sd1);
            KSEL_HIGH:  t = (i == 1 && j == 1) ? 5'sd8 : -5'sd1;
            KSEL_SOBX:  t = (j == 1) ? 5'sd0 :
                            ((i == 1) ? 5'sd2 : 5'sd1) * ((j == 0) ? -5'sd1 : 5'sd1);
            KSEL_SOBY:  t = (i == 1) ? 5'sd0 :
                            ((j == 1) ? 5'sd2 : 5'sd1) * ((i == 0) ? -5'sd1 : 5'sd1);
            default:    t = 5'sd0;
        endcase
        return t;
    endfunction

    // exact divide, round half even, saturate to 0..255
    function automatic logic [7:0] finish(input logic signed [SUM_W-1:0] sum,
                                          input logic [2:0] sel);
        logic [12:0] s;
        logic [25:0] prod;
        logic [12:0] q;
        logic [3:0]  rem;
        s    = 13'(unsigned'(sum));
        prod = 26'(s + 13'd4) * 26'(RECIP9);
        q    = s;
        rem  = s[3:0];
        if (sel == KSEL_MEAN) begin
            q = 13'(prod[25:16]);
        end else if (sel == KSEL_GAUSS) begin
            q = s >> 4;
            if (rem > 4'd8 || (rem == 4'd8 && q[0])) begin
                q = q + 13'd1;
            end
        end
        if (sum <= 0) begin
            return 8'd0;
        end
        return (q > 13'd255) ? 8'd255 : q[7:0];
    endfunction

endpackage

[hw/rtl/r3c_stream_if.sv]
// pixel and result stream interfaces
interface r3c_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       is_pad;

    modport source (output valid, red_in, green_in, blue_in, is_pad, input ready);
    modport sink (input valid, red_in, green_in, blue_in, is_pad, output ready);
endinterface

interface r3c_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

[hw/rtl/r3c_lstore.sv]
// two line stores packed in one memory, read-modify-write with bypass
module r3c_lstore #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [47:0]   wr_data,
    output logic [47:0]   rd_data
);
    logic [47:0] mem [DEPTH];
    logic [47:0] q_reg;
    logic [47:0] byp_data_reg;
    logic        byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    // read of the entry being written this cycle sees the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : q_reg;
endmodule

[hw/rtl/r3c_cell.sv]
// one window column, shifts to its left neighbor
module r3c_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  r3c_pkg::column_t din,
    output r3c_pkg::column_t dout
);
    r3c_pkg::column_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= din;
        end
    end

    assign dout = col_reg;
endmodule

[hw/rtl/r3c_conv.sv]
// masked weighted sums of the window, registered, then divide and saturate
module r3c_conv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [2:0]        ksel,
    input  r3c_pkg::column_t  win [3],
    input  r3c_pkg::ctrl_t    ctrl_in,
    output r3c_pkg::ctrl_t    ctrl_out,
    output logic [23:0]       rgb
);
    logic signed [r3c_pkg::SUM_W-1:0] sum_next [3];
    logic signed [r3c_pkg::SUM_W-1:0] sum_reg [3];
    r3c_pkg::ctrl_t ctrl_reg;
    logic [2:0]  row_ok;
    logic [2:0]  col_ok;
    logic [23:0] px;

    assign row_ok = {ctrl_in.row_bot, 1'b1, ctrl_in.row_top};
    assign col_ok = {ctrl_in.col_right, 1'b1, ctrl_in.col_left};

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    px = (i == 0) ? win[j].top : ((i == 1) ? win[j].mid : win[j].bot);
                    if (row_ok[i] && col_ok[j])
                    begin
                        sum_next[ch] = sum_next[ch] + r3c_pkg::SUM_W'(
                            r3c_pkg::tap(ksel, i, j) * $signed({1'b0, px[8*ch +: 8]}));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign rgb = {r3c_pkg::finish(sum_reg[2], ksel),
                  r3c_pkg::finish(sum_reg[1], ksel),
                  r3c_pkg::finish(sum_reg[0], ksel)};
endmodule

[hw/rtl/rgb_3x3_convolution_filter.sv]
// top level of the rgb 3x3 convolution filter
// Streams RGB pixels in raster order and filters each channel with a 3x3
// kernel chosen by kernel_select (mean, gaussian, high-pass, sobel x, sobel y);
// neighbors outside the image count as zero, sums are divided exactly by 9, 16
// or 1, rounded half to even and clamped to 0..255. One pixel beat is taken
// every clock unless held; its result leaves one row plus one pixel of input
// later, so the host sends image_width+1 pad beats after the frame to drain
// it, and frame_end marks the last result. Internally a beat goes through four
// register stages: counter/address, line store read and window shift, sum,
// and divide/round into the output register. Backpressure on the result side
// holds the whole pipe, so the input is ready whenever the output register is
// empty or being taken. Line stores share one memory of MAX_WIDTH entries with
// one read and one write port; their contents need no clearing after reset.
// Writing image_width or image_height restarts the frame; write the registers
// only when the pipe is empty.
`include "rgb_3x3_convolution_filter_assert.svh"

module rgb_3x3_convolution_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    r3c_pix_if.sink     pix_in,
    r3c_res_if.source   res_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HRW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW  = $clog2(MAX_HEIGHT + 1);

    // configuration registers
    logic [2:0]  ksel_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic        cfg_wr;
    logic        size_wr;

    // position counters, all live at the accept stage
    logic [AW-1:0]  in_col_reg;
    logic [1:0]     in_row_reg;     // saturates at two, only feeds emit
    logic [AW-1:0]  out_col_reg;
    logic [HRW-1:0] out_row_reg;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          adv;
    logic          accept;
    logic          emit;
    logic          in_wrap;
    logic          out_wrap;
    logic          fe;
    r3c_pkg::ctrl_t ctrl0;

    // stage 1: line store data on its way
    logic            s1_valid_reg;
    logic [AW-1:0]   s1_addr_reg;
    r3c_pkg::pixel_t s1_pix_reg;
    r3c_pkg::ctrl_t  s1_ctrl_reg;
    r3c_pkg::ctrl_t  s2_ctrl_reg;
    logic [47:0]     ls_rd;
    logic            shift;

    // window cells, left to right
    r3c_pkg::column_t win [3];
    r3c_pkg::column_t new_col;

    // stage 3 and output
    r3c_pkg::ctrl_t ctrl3;
    logic [23:0]    rgb3;
    logic           out_valid_reg;
    logic [23:0]    out_rgb_reg;
    logic           out_fe_reg;

    // -------- configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign size_wr = cfg_wr && (paddr[3:2] == r3c_pkg::REG_WIDTH ||
                                paddr[3:2] == r3c_pkg::REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ksel_reg   <= r3c_pkg::KSEL_GAUSS;
            width_reg  <= 11'd1024;
            height_reg <= 13'd768;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                r3c_pkg::REG_KERNEL: ksel_reg   <= pwdata[2:0];
                r3c_pkg::REG_WIDTH:  width_reg  <= pwdata[10:0];
                r3c_pkg::REG_HEIGHT: height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            r3c_pkg::REG_KERNEL: prdata = {29'd0, ksel_reg};
            r3c_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            r3c_pkg::REG_HEIGHT: prdata = {19'd0, height_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // sizes clamped to the supported range
    always_comb
    begin
        if (width_reg == 11'd0)
            eff_w = WW'(1);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(width_reg);
        if (height_reg == 13'd0)
            eff_h = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(height_reg);
    end

    // -------- accept stage: counters, edge masks, frame end
    assign adv    = !out_valid_reg || res_out.ready;
    assign accept = pix_in.valid && adv;
    assign pix_in.ready = adv;

    assign emit     = (in_row_reg == 2'd2) || (in_row_reg == 2'd1 && in_col_reg != '0);
    assign in_wrap  = (32'(in_col_reg) + 32'd1) >= 32'(eff_w);
    assign out_wrap = (32'(out_col_reg) + 32'd1) >= 32'(eff_w);
    assign fe       = out_wrap && ((32'(out_row_reg) + 32'd1) >= 32'(eff_h));

    // valid only for an accepted beat that produces a result
    assign ctrl0.valid     = emit && accept;
    assign ctrl0.row_top   = out_row_reg != '0;
    assign ctrl0.row_bot   = (32'(out_row_reg) + 32'd1) < 32'(eff_h);
    assign ctrl0.col_left  = out_col_reg != '0;
    assign ctrl0.col_right = !out_wrap;
    assign ctrl0.frame_end = fe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= 2'd0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (size_wr || (accept && emit && fe))
        begin
            in_col_reg  <= '0;
            in_row_reg  <= 2'd0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept)
        begin
            if (in_wrap)
            begin
                in_col_reg <= '0;
                if (in_row_reg != 2'd2)
                    in_row_reg <= in_row_reg + 2'd1;
            end
            else
            begin
                in_col_reg <= in_col_reg + AW'(1);
            end
            if (emit)
            begin
                if (out_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + HRW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= in_col_reg;
            s1_pix_reg  <= pix_in.is_pad ? 24'd0
                         : {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
            s2_ctrl_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s1_ctrl_reg  <= ctrl0;
            s2_ctrl_reg  <= s1_ctrl_reg;
        end
    end

    // -------- line stores: upper half is two rows up, lower half one row up
    assign shift = s1_valid_reg && adv;

    r3c_lstore #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_lstore (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .wr_en   (shift),
        .wr_addr (s1_addr_reg),
        .wr_data ({ls_rd[23:0], s1_pix_reg}),
        .rd_data (ls_rd)
    );

    // -------- window: new column enters on the right and moves left
    assign new_col.top = ls_rd[47:24];
    assign new_col.mid = ls_rd[23:0];
    assign new_col.bot = s1_pix_reg;

    r3c_cell u_cell_r (.clk(clk), .rst_n(rst_n), .shift(shift), .din(new_col), .dout(win[2]));
    r3c_cell u_cell_m (.clk(clk), .rst_n(rst_n), .shift(shift), .din(win[2]), .dout(win[1]));
    r3c_cell u_cell_l (.clk(clk), .rst_n(rst_n), .shift(shift), .din(win[1]), .dout(win[0]));

    // -------- sums and rounding
    r3c_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .ksel     (ksel_reg),
        .win      (win),
        .ctrl_in  (s2_ctrl_reg),
        .ctrl_out (ctrl3),
        .rgb      (rgb3)
    );

    // -------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctrl3.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_rgb_reg <= rgb3;
            out_fe_reg  <= ctrl3.frame_end;
        end
    end

    assign res_out.valid     = out_valid_reg;
    assign res_out.red_out   = out_rgb_reg[7:0];
    assign res_out.green_out = out_rgb_reg[15:8];
    assign res_out.blue_out  = out_rgb_reg[23:16];
    assign res_out.frame_end = out_fe_reg;

    // -------- checks
    `R3C_ASSERT_NEXT(a_fe_clears, accept && emit && fe && !size_wr, in_col_reg == '0 && out_col_reg == '0 && out_row_reg == '0, "frame end did not clear counters")
    `R3C_ASSERT_NEXT(a_size_clears, size_wr, in_col_reg == '0 && in_row_reg == 2'd0, "size write did not restart frame")
    `R3C_ASSERT_ALWAYS(a_col_range, 32'(in_col_reg) < 32'(eff_w) || size_wr || $past(cfg_wr), "input column beyond width")

endmodule
